// ----- hw/rtl/sab_pkg.sv -----
package sab_pkg;

  localparam int SPRITE_MAX_W = 64;
  localparam int SPRITE_MAX_H = 64;
  localparam int STORE_DEPTH  = SPRITE_MAX_W * SPRITE_MAX_H;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  // divider layout: 16 quotient bits, four per stage
  localparam int DIV_W         = 16;
  localparam int DIV_PER_STAGE = 4;
  localparam int DIV_STAGES    = DIV_W / DIV_PER_STAGE;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_BLEND = 1'b1;

  // register indexes
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_COL_OFFSET = 3'd4;
  localparam logic [2:0] REG_ROW_OFFSET = 3'd5;
  localparam logic [2:0] REG_KEY_ENABLE = 3'd6;
  localparam logic [2:0] REG_KEY_THRESH = 3'd7;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  typedef struct packed {
    logic [10:0]      rem;
    logic [DIV_W-1:0] qd;
  } div_t;

  typedef struct packed {
    logic              kind;
    logic [9:0]        col;
    logic [9:0]        row;
    logic [31:0]       pix;
    logic              ld_ok;
    logic [ADDR_W-1:0] ld_addr;
  } ctx_t;

  // a few restoring division steps
  function automatic div_t div_steps(div_t cur, logic [10:0] dv);
    div_t        w;
    logic [11:0] t;
    w = cur;
    for (int i = 0; i < DIV_PER_STAGE; i++) begin
      t = {w.rem, w.qd[DIV_W-1]};
      w.qd = {w.qd[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dv}) begin
        t = t - {1'b0, dv};
        w.qd[0] = 1'b1;
      end
      w.rem = t[10:0];
    end
    return w;
  endfunction

endpackage

// ----- hw/rtl/scaled_alpha_blit_core.sv -----
// Sprite blitter: load items (kind 0) write keyed 32-bit words into a 4096-word sprite
// store, blend items (kind 1) scale their coordinates nearest-neighbour onto the
// sprite and alpha-blend the sprite word over the destination pixel. One item is
// taken every cycle and busy never rises; each blend result appears on the result
// ports with out_valid for one cycle, and loads give no result. Between an item and
// its result lie the scale products, the coordinate divider (four stages of four
// quotient bits), the offset clamp, the store read and the blend multiply. The
// receiver cannot stall: it must take every result beat when out_valid is high.
module scaled_alpha_blit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [9:0]  col,
  input  logic [9:0]  row,
  input  logic [31:0] pixel,
  output logic        out_valid,
  output logic [31:0] out_pixel,
  output logic [9:0]  out_col,
  output logic [9:0]  out_row,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sab_pkg::*;

  localparam int NS = 9;

  logic [6:0]  src_width, src_height;
  logic [10:0] dst_width, dst_height;
  logic [5:0]  src_col_offset, src_row_offset;
  logic        key_enable;
  logic [8:0]  key_threshold;

  // configuration writes
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width      <= 7'd64;
      src_height     <= 7'd64;
      dst_width      <= 11'd40;
      dst_height     <= 11'd40;
      src_col_offset <= 6'd0;
      src_row_offset <= 6'd0;
      key_enable     <= 1'b1;
      key_threshold  <= 9'd30;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_SRC_WIDTH:  src_width      <= pwdata[6:0];
        REG_SRC_HEIGHT: src_height     <= pwdata[6:0];
        REG_DST_WIDTH:  dst_width      <= pwdata[10:0];
        REG_DST_HEIGHT: dst_height     <= pwdata[10:0];
        REG_COL_OFFSET: src_col_offset <= pwdata[5:0];
        REG_ROW_OFFSET: src_row_offset <= pwdata[5:0];
        REG_KEY_ENABLE: key_enable     <= pwdata[0];
        REG_KEY_THRESH: key_threshold  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      REG_SRC_WIDTH:  prdata = {25'd0, src_width};
      REG_SRC_HEIGHT: prdata = {25'd0, src_height};
      REG_DST_WIDTH:  prdata = {21'd0, dst_width};
      REG_DST_HEIGHT: prdata = {21'd0, dst_height};
      REG_COL_OFFSET: prdata = {26'd0, src_col_offset};
      REG_ROW_OFFSET: prdata = {26'd0, src_row_offset};
      REG_KEY_ENABLE: prdata = {31'd0, key_enable};
      REG_KEY_THRESH: prdata = {23'd0, key_threshold};
      default:        prdata = 32'd0;
    endcase
  end

  // clamped sizes
  logic [6:0]  sw, sh;
  logic [10:0] dw, dh;
  always_comb begin
    sw = (src_width == 7'd0) ? 7'd1 :
         (src_width > 7'(SPRITE_MAX_W)) ? 7'(SPRITE_MAX_W) : src_width;
    sh = (src_height == 7'd0) ? 7'd1 :
         (src_height > 7'(SPRITE_MAX_H)) ? 7'(SPRITE_MAX_H) : src_height;
    dw = (dst_width == 11'd0) ? 11'd1 : dst_width;
    dh = (dst_height == 11'd0) ? 11'd1 : dst_height;
  end

  assign busy = 1'b0;

  // entry: keying, load address and load range check
  logic        accept;
  logic        keyed;
  logic [31:0] pix_in;
  ctx_t        ctx_in;
  assign accept = start && !busy;
  always_comb begin
    keyed = key_enable && ({1'b0, pixel[7:0]} < key_threshold) &&
            ({1'b0, pixel[15:8]} < key_threshold) &&
            ({1'b0, pixel[23:16]} < key_threshold);
    pix_in = (kind == KIND_LOAD && keyed) ? 32'd0 : pixel;
    ctx_in.kind    = kind;
    ctx_in.col     = col;
    ctx_in.row     = row;
    ctx_in.pix     = pix_in;
    ctx_in.ld_ok   = ({3'd0, col} < {3'd0, sw}) && ({3'd0, row} < {3'd0, sh});
    ctx_in.ld_addr = ADDR_W'({6'd0, row[5:0]} * {5'd0, sw} + {6'd0, col[5:0]});
  end

  logic        v   [NS];
  ctx_t        ctx [NS];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) v[i] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v[0] <= accept;
      for (int i = 1; i < NS; i++) v[i] <= v[i-1];
      out_valid <= v[NS-1] && ctx[NS-1].kind == KIND_BLEND;
    end
  end

  // item context travels with the stages
  always_ff @(posedge clk) begin
    ctx[0] <= ctx_in;
    for (int i = 1; i < NS; i++) ctx[i] <= ctx[i-1];
  end

  // scale products and divider stages
  div_t cdiv [DIV_STAGES+1];
  div_t rdiv [DIV_STAGES+1];
  always_ff @(posedge clk) begin
    cdiv[0].rem <= 11'd0;
    cdiv[0].qd  <= DIV_W'({6'd0, col} * {9'd0, sw});
    rdiv[0].rem <= 11'd0;
    rdiv[0].qd  <= DIV_W'({6'd0, row} * {9'd0, sh});
    for (int k = 1; k <= DIV_STAGES; k++) begin
      cdiv[k] <= div_steps(cdiv[k-1], dw);
      rdiv[k] <= div_steps(rdiv[k-1], dh);
    end
  end

  // offset and clamp to the sprite
  logic [6:0]  sx, sy;
  logic [16:0] sxs, sys;
  always_comb begin
    sxs = 17'(cdiv[DIV_STAGES].qd) + 17'(src_col_offset);
    sys = 17'(rdiv[DIV_STAGES].qd) + 17'(src_row_offset);
  end
  always_ff @(posedge clk) begin
    sx <= (sxs >= 17'(sw)) ? sw - 7'd1 : sxs[6:0];
    sy <= (sys >= 17'(sh)) ? sh - 7'd1 : sys[6:0];
  end

  // store address
  logic [ADDR_W-1:0] maddr;
  always_ff @(posedge clk) begin
    if (ctx[5].kind == KIND_LOAD) maddr <= ctx[5].ld_addr;
    else maddr <= ADDR_W'(sy * sw + {7'd0, sx});
  end

  // sprite store
  logic [31:0] store [STORE_DEPTH];
  logic [31:0] rdata;
  always_ff @(posedge clk) begin
    if (v[6] && ctx[6].kind == KIND_LOAD && ctx[6].ld_ok) store[maddr] <= ctx[6].pix;
    rdata <= store[maddr];
  end

  // blend multiplies
  logic signed [16:0] prod [3];
  logic [31:0]        sc;
  always_ff @(posedge clk) begin
    sc <= rdata;
    for (int b = 0; b < 3; b++) begin
      prod[b] <= ($signed({9'd0, rdata[8*b +: 8]}) - $signed({9'd0, ctx[7].pix[8*b +: 8]}))
                 * $signed({9'd0, rdata[31:24]});
    end
  end

  // divide by 255, add and select
  logic [31:0] mix;
  logic [15:0] mag, qt;
  logic [16:0] tmp;
  logic [7:0]  db;
  always_comb begin
    mix = 32'd0;
    mag = 16'd0;
    qt  = 16'd0;
    tmp = 17'd0;
    db  = 8'd0;
    for (int b = 0; b < 3; b++) begin
      db  = ctx[8].pix[8*b +: 8];
      mag = prod[b][16] ? 16'(-prod[b]) : prod[b][15:0];
      tmp = 17'(mag) + 17'd1 + 17'(mag[15:8]);
      qt  = 16'(tmp[16:8]);
      mix[8*b +: 8] = prod[b][16] ? db - qt[7:0] : db + qt[7:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    out_col <= ctx[8].col;
    out_row <= ctx[8].row;
    if (sc[31:24] == ALPHA_CLEAR) out_pixel <= ctx[8].pix;
    else if (sc[31:24] == ALPHA_OPAQUE) out_pixel <= sc;
    else out_pixel <= mix;
  end

endmodule

// ----- tb/scaled_alpha_blit_core_test.sv -----
module scaled_alpha_blit_core_test;
  import sab_pkg::*;

  typedef struct {
    logic        kind;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [31:0] pix;
  } item_t;

  typedef struct {
    logic [31:0] pix;
    logic [9:0]  col;
    logic [9:0]  row;
  } blend_out_t;

  logic        clk, rst, start, busy, kind;
  logic [9:0]  col, row;
  logic [31:0] pixel;
  logic        out_valid;
  logic [31:0] out_pixel;
  logic [9:0]  out_col, out_row;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  scaled_alpha_blit_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .col(col), .row(row),
    .pixel(pixel), .out_valid(out_valid), .out_pixel(out_pixel), .out_col(out_col),
    .out_row(out_row), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // register copy and sprite store as the block should hold them
  logic [31:0] regs [8];
  logic [31:0] sprite_mem [STORE_DEPTH];
  bit          loaded [STORE_DEPTH];

  item_t      pend_q [$];
  blend_out_t blend_q [$];
  int         errors, n_loads, n_blends, n_results, n_phases;
  bit         beat_taken, calm;
  int         idle_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_dim(logic [31:0] v, int max);
    if (v < 1) return 1;
    if (v > max) return max;
    return v;
  endfunction

  // nearest-neighbour source index for a destination coordinate
  function automatic int sprite_index(logic [9:0] c, logic [9:0] r);
    int sw, sh, dw, dh, sx, sy;
    sw = clamp_dim(regs[REG_SRC_WIDTH], SPRITE_MAX_W);
    sh = clamp_dim(regs[REG_SRC_HEIGHT], SPRITE_MAX_H);
    dw = (regs[REG_DST_WIDTH] == 0) ? 1 : regs[REG_DST_WIDTH];
    dh = (regs[REG_DST_HEIGHT] == 0) ? 1 : regs[REG_DST_HEIGHT];
    sx = regs[REG_COL_OFFSET] + (c * sw) / dw;
    sy = regs[REG_ROW_OFFSET] + (r * sh) / dh;
    if (sx >= sw) sx = sw - 1;
    if (sy >= sh) sy = sh - 1;
    return sy * sw + sx;
  endfunction

  function automatic logic [31:0] keyed_word(logic [31:0] p);
    if (regs[REG_KEY_ENABLE][0] && p[7:0] < regs[REG_KEY_THRESH]
        && p[15:8] < regs[REG_KEY_THRESH] && p[23:16] < regs[REG_KEY_THRESH])
      return 32'h0;
    return p;
  endfunction

  function automatic logic [31:0] blended(logic [31:0] s, logic [31:0] d);
    logic [31:0] res;
    int          a, diff, r;
    a = s[31:24];
    if (s[31:24] == ALPHA_CLEAR) return d;
    if (s[31:24] == ALPHA_OPAQUE) return s;
    res = 32'h0;
    for (int k = 0; k < 3; k++) begin
      diff = int'(s[k*8 +: 8]) - int'(d[k*8 +: 8]);
      r = int'(d[k*8 +: 8]) + (diff * a) / 255;
      res[k*8 +: 8] = r[7:0];
    end
    return res;
  endfunction

  // driver: one beat per start, random idle bursts
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      beat_taken = 1'b0;
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pend_q.size() != 0 && !calm && $urandom_range(11) == 0) begin
        idle_left = $urandom_range(18, 1) - 1;
        start <= 1'b0;
      end else if (pend_q.size() != 0) begin
        item_t it;
        it = pend_q.pop_front();
        start <= 1'b1;
        kind  <= it.kind;
        col   <= it.col;
        row   <= it.row;
        pixel <= it.pix;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted beats, check result beats
  always @(posedge clk) begin
    if (!rst && out_valid) begin
      n_results++;
      if (blend_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result pixel %h col %0d row %0d",
                 $time, out_pixel, out_col, out_row);
      end else begin
        blend_out_t e;
        e = blend_q.pop_front();
        if (out_pixel !== e.pix) begin
          errors++;
          $display("%0t: out_pixel expected %h actual %h", $time, e.pix, out_pixel);
        end
        if (out_col !== e.col) begin
          errors++;
          $display("%0t: out_col expected %0d actual %0d", $time, e.col, out_col);
        end
        if (out_row !== e.row) begin
          errors++;
          $display("%0t: out_row expected %0d actual %0d", $time, e.row, out_row);
        end
      end
    end
    if (!rst && start && !busy) begin
      int sw, sh;
      beat_taken = 1'b1;
      sw = clamp_dim(regs[REG_SRC_WIDTH], SPRITE_MAX_W);
      sh = clamp_dim(regs[REG_SRC_HEIGHT], SPRITE_MAX_H);
      if (kind == KIND_LOAD) begin
        n_loads++;
        if (col < sw && row < sh) sprite_mem[row * sw + col] = keyed_word(pixel);
      end else begin
        n_blends++;
        blend_q.push_back('{blended(sprite_mem[sprite_index(col, row)], pixel), col, row});
      end
    end
  end

  task automatic add_load(int c, int r, logic [31:0] p);
    int sw, sh;
    sw = clamp_dim(regs[REG_SRC_WIDTH], SPRITE_MAX_W);
    sh = clamp_dim(regs[REG_SRC_HEIGHT], SPRITE_MAX_H);
    pend_q.push_back('{KIND_LOAD, c[9:0], r[9:0], p});
    if (c < sw && r < sh) loaded[r * sw + c] = 1'b1;
  endtask

  // a blend never reads a sprite entry that was not loaded first
  task automatic add_blend(int c, int r, logic [31:0] p);
    int idx, sw;
    sw = clamp_dim(regs[REG_SRC_WIDTH], SPRITE_MAX_W);
    idx = sprite_index(c[9:0], r[9:0]);
    if (!loaded[idx]) add_load(idx % sw, idx / sw, sprite_word());
    pend_q.push_back('{KIND_BLEND, c[9:0], r[9:0], p});
  endtask

  // sprite words spread over clear, opaque, partial and near-black
  function automatic logic [31:0] sprite_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(4))
      0: w[31:24] = ALPHA_CLEAR;
      1: w[31:24] = ALPHA_OPAQUE;
      2: w[23:0] = {8'($urandom_range(40)), 8'($urandom_range(40)), 8'($urandom_range(40))};
      default: ;
    endcase
    return w;
  endfunction

  task automatic wait_idle();
    while (pend_q.size() != 0 || start || idle_left != 0) @(posedge clk);
    while (blend_q.size() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SRC_WIDTH, REG_SRC_HEIGHT: regs[idx] = v & 32'h7F;
      REG_DST_WIDTH, REG_DST_HEIGHT: regs[idx] = v & 32'h7FF;
      REG_COL_OFFSET, REG_ROW_OFFSET: regs[idx] = v & 32'h3F;
      REG_KEY_ENABLE: regs[idx] = v & 32'h1;
      default: regs[idx] = v & 32'h1FF;
    endcase
  endtask

  task automatic set_all(int sw, int sh, int dw, int dh, int co, int ro, int ke, int kt);
    wait_idle();
    reg_write(REG_SRC_WIDTH, sw);
    reg_write(REG_SRC_HEIGHT, sh);
    reg_write(REG_DST_WIDTH, dw);
    reg_write(REG_DST_HEIGHT, dh);
    reg_write(REG_COL_OFFSET, co);
    reg_write(REG_ROW_OFFSET, ro);
    reg_write(REG_KEY_ENABLE, ke);
    reg_write(REG_KEY_THRESH, kt);
    foreach (loaded[i]) loaded[i] = 1'b0;
    n_phases++;
  endtask

  // loads of the sprite, then blends over the rectangle, with some noise
  task automatic random_phase(int n);
    int sw, sh, dw, dh;
    sw = clamp_dim(regs[REG_SRC_WIDTH], SPRITE_MAX_W);
    sh = clamp_dim(regs[REG_SRC_HEIGHT], SPRITE_MAX_H);
    dw = (regs[REG_DST_WIDTH] == 0) ? 1 : regs[REG_DST_WIDTH];
    dh = (regs[REG_DST_HEIGHT] == 0) ? 1 : regs[REG_DST_HEIGHT];
    for (int i = 0; i < n / 4; i++) begin
      if ($urandom_range(9) == 0) add_load($urandom_range(1023), $urandom_range(1023), $urandom);
      else add_load($urandom_range(sw - 1), $urandom_range(sh - 1), sprite_word());
    end
    for (int i = 0; i < n - n / 4; i++) begin
      case ($urandom_range(9))
        0: add_blend($urandom_range(1023), $urandom_range(1023), $urandom);
        1: add_load($urandom_range(sw - 1), $urandom_range(sh - 1), sprite_word());
        default: add_blend($urandom_range(dw > 1024 ? 1023 : dw - 1),
                           $urandom_range(dh > 1024 ? 1023 : dh - 1), $urandom);
      endcase
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; kind = 1'b0; col = '0; row = '0; pixel = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; n_loads = 0; n_blends = 0; n_results = 0; n_phases = 1;
    beat_taken = 1'b0; calm = 1'b0; idle_left = 0;
    regs = '{64, 64, 40, 40, 0, 0, 1, 30};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: keying edges, range edges, alpha edges
    add_load(0, 0, 32'h001D1D1D);
    add_load(1, 0, 32'hFF1E1D1D);
    add_load(63, 63, 32'hFFFFFFFF);
    add_load(2, 0, 32'h80405060);
    add_load(3, 0, 32'h01FF00FF);
    add_load(4, 0, 32'hFE00FF00);
    add_load(64, 0, 32'hFFFFFFFF);
    add_load(0, 1023, 32'hFFFFFFFF);
    add_load(1023, 1023, 32'h12345678);
    add_blend(0, 0, 32'hFFFFFFFF);
    add_blend(0, 0, 32'h00000000);
    add_blend(1, 0, 32'h00ABCDEF);
    add_blend(2, 0, 32'h00FFFFFF);
    add_blend(2, 0, 32'h00000000);
    add_blend(3, 0, 32'hFF00FF00);
    add_blend(4, 0, 32'h00FF00FF);
    add_blend(39, 39, 32'h5A5A5A5A);
    add_blend(1023, 1023, 32'hA5A5A5A5);
    add_blend(1023, 0, 32'h0F0F0F0F);
    add_blend(0, 1023, 32'hF0F0F0F0);

    // configuration sweep including out-of-range and extreme settings
    set_all(8, 8, 16, 16, 0, 0, 1, 30);     random_phase(150);
    set_all(0, 0, 0, 0, 0, 0, 0, 0);        random_phase(60);
    set_all(127, 127, 2047, 2047, 63, 63, 1, 256); random_phase(160);
    set_all(1, 64, 1024, 1, 0, 5, 1, 0);    random_phase(100);
    set_all(5, 3, 7, 11, 2, 1, 1, 511);     random_phase(150);
    set_all(64, 64, 1, 1024, 10, 63, 0, 256); random_phase(160);
    set_all(12, 9, 30, 20, 0, 0, 1, 128);   random_phase(150);
    set_all(3, 17, 3, 40, 1, 0, 1, 64);     random_phase(150);
    set_all(16, 4, 1000, 5, 7, 2, 1, 30);   calm = 1'b1; random_phase(150);
    wait_idle();

    $display("covered %0d load and %0d blend beats over %0d register settings,",
             n_loads, n_blends, n_phases);
    $display("%0d blended results checked", n_results);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
